[rtl/core/wsfd_pkg.sv]
// Package for the WebSocket frame decoder: header positions, result kinds,
// opcodes, length codes and the result record. No dependencies.
package wsfd_pkg;

	// Header position codes
	localparam logic [3:0] POS_FIRST   = 4'd0;
	localparam logic [3:0] POS_SECOND  = 4'd1;
	localparam logic [3:0] POS_EXT     = 4'd2;
	localparam logic [3:0] POS_KEY     = 4'd10;
	localparam logic [3:0] POS_KEY_END = 4'd13;
	localparam logic [3:0] POS_PAYLOAD = 4'd14;

	// Result kinds
	localparam logic [1:0] KIND_TEXT  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;

	// Opcodes and length codes of interest
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [6:0] LEN_16   = 7'd126;
	localparam logic [6:0] LEN_64   = 7'd127;

	// One result
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} res_t;

endpackage

[rtl/core/wsfd_parser.sv]
// Input register and frame parser of the WebSocket frame decoder.
// Depends on wsfd_pkg.
module wsfd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_data,
	input  logic             res_ready,
	output logic             res_valid,
	output wsfd_pkg::res_t   res
);
	import wsfd_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        advance;

	logic [3:0]  pos_q, pos_nx;
	logic [3:0]  opcode_q, opcode_nx;
	logic        mask_q, mask_nx;
	logic [6:0]  lcode_q, lcode_nx;
	logic [63:0] rem_q, rem_nx;
	logic [31:0] key_q, key_nx;
	logic [1:0]  phase_q, phase_nx;
	logic        closed_q, closed_nx;

	logic        go_after_len, go_begin, go_end, end_empty;
	logic [2:0]  ext_idx;
	logic [3:0]  pos_dif;
	logic [7:0]  key_byte;
	logic        res_v_c;
	res_t        res_c;

	// Input register
	assign in_ready = !valid_s1 || res_ready;
	assign advance  = valid_s1 && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	assign pos_dif = pos_q - POS_EXT;
	assign ext_idx = pos_dif[2:0];

	// Key byte for the current payload index, first key byte on top
	always_comb begin
		case (phase_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// Parse one byte
	always_comb begin
		pos_nx       = pos_q;
		opcode_nx    = opcode_q;
		mask_nx      = mask_q;
		lcode_nx     = lcode_q;
		rem_nx       = rem_q;
		key_nx       = key_q;
		phase_nx     = phase_q;
		closed_nx    = closed_q;
		go_after_len = 1'b0;
		go_begin     = 1'b0;
		go_end       = 1'b0;
		end_empty    = 1'b0;
		res_v_c      = 1'b0;
		res_c        = '{kind: KIND_TEXT, data: 8'd0, last: 1'b0};

		if (!closed_q) begin
			if (pos_q == POS_SECOND) begin
				mask_nx  = data_s1[7];
				lcode_nx = data_s1[6:0];
				if (data_s1[6:0] == LEN_16 || data_s1[6:0] == LEN_64) begin
					rem_nx = 64'd0;
					pos_nx = POS_EXT;
				end else begin
					rem_nx       = {57'd0, data_s1[6:0]};
					go_after_len = 1'b1;
				end
			end else if (pos_q >= POS_EXT && pos_q < POS_KEY) begin
				// Extended length, big-endian
				rem_nx = {rem_q[55:0], data_s1};
				if ((lcode_q == LEN_16) ? (ext_idx >= 3'd1) : (ext_idx == 3'd7)) begin
					go_after_len = 1'b1;
				end else begin
					pos_nx = pos_q + 4'd1;
				end
			end else if (pos_q >= POS_KEY && pos_q <= POS_KEY_END) begin
				key_nx = {key_q[23:0], data_s1};
				if (pos_q == POS_KEY_END) begin
					go_begin = 1'b1;
				end else begin
					pos_nx = pos_q + 4'd1;
				end
			end else if (pos_q == POS_PAYLOAD) begin
				phase_nx = phase_q + 2'd1;
				rem_nx   = rem_q - 64'd1;
				if (opcode_q == OP_TEXT) begin
					res_v_c    = 1'b1;
					res_c.kind = KIND_TEXT;
					res_c.data = mask_q ? (data_s1 ^ key_byte) : data_s1;
					res_c.last = (rem_nx == 64'd0);
					if (rem_nx == 64'd0) begin
						pos_nx = POS_FIRST;
					end
				end else if (rem_nx == 64'd0) begin
					go_end = 1'b1;
				end
			end else begin
				// First header byte, also any unused position
				opcode_nx = data_s1[3:0];
				pos_nx    = POS_SECOND;
			end

			// Length known: key next, or straight to the payload
			if (go_after_len) begin
				if (mask_nx) begin
					key_nx = 32'd0;
					pos_nx = POS_KEY;
				end else begin
					go_begin = 1'b1;
				end
			end
			if (go_begin) begin
				phase_nx = 2'd0;
				if (rem_nx == 64'd0) begin
					go_end    = 1'b1;
					end_empty = 1'b1;
				end else begin
					pos_nx = POS_PAYLOAD;
				end
			end
			// Frame over
			if (go_end) begin
				pos_nx = POS_FIRST;
				if (opcode_q == OP_CLOSE) begin
					closed_nx = 1'b1;
					res_v_c   = 1'b1;
					res_c     = '{kind: KIND_CLOSE, data: 8'd0, last: 1'b1};
				end else if (opcode_q == OP_TEXT && end_empty) begin
					res_v_c = 1'b1;
					res_c   = '{kind: KIND_EMPTY, data: 8'd0, last: 1'b1};
				end
			end
		end
	end

	assign res_valid = advance && res_v_c;
	assign res       = res_c;

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_FIRST;
			opcode_q <= 4'd0;
			mask_q   <= 1'b0;
			lcode_q  <= 7'd0;
			rem_q    <= 64'd0;
			key_q    <= 32'd0;
			phase_q  <= 2'd0;
			closed_q <= 1'b0;
		end else if (advance) begin
			pos_q    <= pos_nx;
			opcode_q <= opcode_nx;
			mask_q   <= mask_nx;
			lcode_q  <= lcode_nx;
			rem_q    <= rem_nx;
			key_q    <= key_nx;
			phase_q  <= phase_nx;
			closed_q <= closed_nx;
		end
	end

	// Once closed, stays closed
	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q) else $error("closed flag dropped");

	// Nothing comes out after a close
	a_closed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |-> !res_valid) else $error("result after close");

	// In the payload there is always at least one byte left
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == POS_PAYLOAD) |-> (rem_q != 64'd0)) else $error("empty payload count");

endmodule

[rtl/core/wsfd_out_skid.sv]
// Output register with skid entry for the decoder results.
// Depends on wsfd_pkg.
module wsfd_out_skid (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wsfd_pkg::res_t  push_res,
	output logic            push_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output wsfd_pkg::res_t  out_res
);
	import wsfd_pkg::*;

	logic main_valid_q, skid_valid_q;
	res_t main_q, skid_q;

	assign push_ready = !skid_valid_q;
	assign out_valid  = main_valid_q;
	assign out_res    = main_q;

	// Main register refills from the skid entry first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || out_ready) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || out_ready) begin
			main_q <= skid_valid_q ? skid_q : push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	// Skid entry only holds a request behind a full main register
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q) else $error("skid without main");

	// No push is taken while the skid entry is full
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push) else $error("push into full skid");

endmodule

[rtl/core/websocket_frame_decoder.sv]
// WebSocket frame decoder, top level: parser and output skid stage.
// Depends on wsfd_pkg, wsfd_parser and wsfd_out_skid.
//
// Takes a received byte stream, one byte per request, and parses RFC 6455
// frames back to back. Each byte of a text frame payload comes out unmasked
// as a request with tuser = 0 and tlast on the final byte; an empty text
// frame gives one request with tuser = 1; a close frame gives one request
// with tuser = 2 on its last byte, after which the block drops all input
// until reset. Other opcodes are consumed silently and FIN is ignored.
// The block takes one byte per clock while the skid entry is free: every
// byte passes the input register, is parsed combinationally against the
// frame state and lands in the output register, and a two-entry output
// stage keeps the input running while one result waits for the sink.
module websocket_frame_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] payload_byte
	output logic [1:0] m_tuser,   // [1:0] result_kind
	output logic       m_tlast
);
	import wsfd_pkg::*;

	logic res_valid, res_ready;
	res_t res, out_res;

	wsfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	wsfd_out_skid u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_res   (res),
		.push_ready (res_ready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (out_res)
	);

	assign m_tdata = out_res.data;
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

	// Only byte results carry data
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_TEXT) |-> (m_tdata == 8'd0 && m_tlast))
		else $error("non-byte result with data");

endmodule
